// File: design/smtd_pkg.sv
// Shared types and constants for the stereo multitap delay chorus.
// No dependencies; every design file imports this package.
package smtd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int OUT_BITS    = 22;
    localparam int GAIN_BITS   = 4;

    localparam int MAIN_DELAY  = 7000;
    localparam int TAP1_DELAY  = 180;
    localparam int TAP2_DELAY  = 340;

    localparam int MAIN_W = (MAIN_DELAY > 1) ? $clog2(MAIN_DELAY) : 1;
    localparam int TAP1_W = (TAP1_DELAY > 1) ? $clog2(TAP1_DELAY) : 1;
    localparam int TAP2_W = (TAP2_DELAY > 1) ? $clog2(TAP2_DELAY) : 1;

    // both channels share one memory per line, channel is the address MSB
    localparam int MAIN_DEPTH = 2 << MAIN_W;
    localparam int TAP1_DEPTH = 2 << TAP1_W;
    localparam int TAP2_DEPTH = 2 << TAP2_W;

    localparam int SUM_BITS  = SAMPLE_BITS + 2;
    localparam int PROD_BITS = SUM_BITS + GAIN_BITS + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_ENABLE = 2'd2;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 4'd2;

    localparam logic CH_RIGHT = 1'b0;
    localparam logic CH_LEFT  = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          ch;
        logic [MAIN_W-1:0]             mp;
        logic [TAP1_W-1:0]             p1;
        logic [TAP2_W-1:0]             p2;
        logic                          main_vld;
        logic                          tap1_vld;
        logic                          tap2_vld;
    } t_cmd;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] dry;
        logic signed [OUT_BITS-1:0] wet;
        logic                       ch;
        logic                       dry_en;
        logic                       wet_en;
    } t_res;

    typedef struct packed {
        logic                   we;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg;

endpackage

// File: design/smtd_front.sv
// Front end: accepts samples, tracks channel, pointers and line fill state,
// and queues one command per sample for the back end. Uses smtd_pkg.
module smtd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [smtd_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_cmd_valid,
    output smtd_pkg::t_cmd                     o_cmd,
    input  logic                               i_cmd_pop
);
    import smtd_pkg::*;

    logic              r_ch;
    logic [MAIN_W-1:0] r_mp;
    logic [TAP1_W-1:0] r_p1;
    logic [TAP2_W-1:0] r_p2;
    // set once a line has wrapped: every entry has then been written
    logic              r_main_full, r_tap1_full, r_tap2_full;

    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_cmd        cmd_in;

    logic main_wrap, tap1_wrap, tap2_wrap;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;

    assign main_wrap = (r_mp == MAIN_W'(MAIN_DELAY - 1));
    assign tap1_wrap = (r_p1 == TAP1_W'(TAP1_DELAY - 1));
    assign tap2_wrap = (r_p2 == TAP2_W'(TAP2_DELAY - 1));

    always_comb begin
        cmd_in.sample   = i_sample_in;
        cmd_in.ch       = r_ch;
        cmd_in.mp       = r_mp;
        cmd_in.p1       = r_p1;
        cmd_in.p2       = r_p2;
        cmd_in.main_vld = r_main_full;
        cmd_in.tap1_vld = r_tap1_full;
        cmd_in.tap2_vld = r_tap2_full;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch        <= CH_RIGHT;
            r_mp        <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
            r_main_full <= 1'b0;
            r_tap1_full <= 1'b0;
            r_tap2_full <= 1'b0;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
                r_ch <= ~r_ch;
                if (r_ch == CH_LEFT) begin
                    r_mp <= main_wrap ? '0 : r_mp + 1'b1;
                    r_p1 <= tap1_wrap ? '0 : r_p1 + 1'b1;
                    r_p2 <= tap2_wrap ? '0 : r_p2 + 1'b1;
                    if (main_wrap) r_main_full <= 1'b1;
                    if (tap1_wrap) r_tap1_full <= 1'b1;
                    if (tap2_wrap) r_tap2_full <= 1'b1;
                end
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/smtd_back.sv
// Back end: delay line memories, configuration registers and the tap sum.
// Reads in the idle state, computes and writes in the exec state. Uses smtd_pkg.
module smtd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smtd_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  smtd_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_res_push,
    output smtd_pkg::t_res o_res,
    input  logic           i_res_ready
);
    import smtd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_bstate;

    t_bstate r_state, n_state;

    logic [GAIN_BITS-1:0] r_gain;
    logic                 r_dry_en, r_wet_en;

    logic [SAMPLE_BITS-1:0] r_main_mem [MAIN_DEPTH];
    logic [SAMPLE_BITS-1:0] r_tap1_mem [TAP1_DEPTH];
    logic [SAMPLE_BITS-1:0] r_tap2_mem [TAP2_DEPTH];
    logic [SAMPLE_BITS-1:0] r_main_q, r_tap1_q, r_tap2_q;

    t_cmd r_cmd;

    logic signed [SAMPLE_BITS-1:0] main_out, tap1_out, tap2_out;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [PROD_BITS-1:0]   prod;
    logic                          need_push, done, rd_en;

    assign rd_en     = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop = rd_en;

    // never-written entries read as zero
    assign main_out = r_cmd.main_vld ? r_main_q : '0;
    assign tap1_out = r_cmd.tap1_vld ? r_tap1_q : '0;
    assign tap2_out = r_cmd.tap2_vld ? r_tap2_q : '0;

    assign sum  = SUM_BITS'(main_out) + SUM_BITS'(tap1_out) + SUM_BITS'(tap2_out);
    assign prod = PROD_BITS'(sum) * $signed({1'b0, r_gain});

    assign need_push  = r_dry_en || r_wet_en;
    assign done       = (r_state == ST_EXEC) && (!need_push || i_res_ready);
    assign o_res_push = done && need_push;

    always_comb begin
        o_res.dry    = OUT_BITS'(r_cmd.sample);
        o_res.wet    = prod[OUT_BITS-1:0];
        o_res.ch     = r_cmd.ch;
        o_res.dry_en = r_dry_en;
        o_res.wet_en = r_wet_en;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_cmd_valid) n_state = ST_EXEC;
            ST_EXEC: if (done)        n_state = ST_IDLE;
            default:                  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cmd    <= i_cmd;
            r_main_q <= r_main_mem[{i_cmd.ch, i_cmd.mp}];
            r_tap1_q <= r_tap1_mem[{i_cmd.ch, i_cmd.p1}];
            r_tap2_q <= r_tap2_mem[{i_cmd.ch, i_cmd.p2}];
        end
        if (done) begin
            r_main_mem[{r_cmd.ch, r_cmd.mp}] <= r_cmd.sample;
            r_tap1_mem[{r_cmd.ch, r_cmd.p1}] <= main_out;
            r_tap2_mem[{r_cmd.ch, r_cmd.p2}] <= main_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_gain   <= GAIN_RESET;
            r_dry_en <= 1'b1;
            r_wet_en <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_TAP_GAIN:   r_gain   <= i_cfg.data[GAIN_BITS-1:0];
                    CFG_DRY_ENABLE: r_dry_en <= i_cfg.data[0];
                    CFG_WET_ENABLE: r_wet_en <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: design/smtd_out.sv
// Result queue and serializer: holds up to two dry/wet pairs and emits
// the dry result before the wet one. Uses smtd_pkg.
module smtd_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smtd_pkg::t_res i_res,
    output logic           o_res_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic signed [smtd_pkg::OUT_BITS-1:0] o_sample_out,
    output logic           o_is_wet,
    output logic           o_channel,
    output logic           o_last
);
    import smtd_pkg::*;

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       r_wet_phase;   // dry part of the head entry already sent
    t_res       head;
    logic       send_dry, pop, take;

    assign head        = r_q[r_rp];
    assign o_res_ready = (r_cnt != 2'd2);
    assign o_valid     = (r_cnt != 2'd0);

    assign send_dry     = head.dry_en && !r_wet_phase;
    assign o_sample_out = send_dry ? head.dry : head.wet;
    assign o_is_wet     = !send_dry;
    assign o_channel    = head.ch;
    assign o_last       = !send_dry || !head.wet_en;

    assign take = o_valid && i_ready;
    assign pop  = take && o_last;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
            r_wet_phase <= 1'b0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop)    r_rp <= ~r_rp;
            if (take)   r_wet_phase <= !o_last;
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/stereo_multitap_delay_chorus_unit.sv
// Stereo multitap delay chorus, top level. The back end takes one sample at a
// time: a read in its idle state, then compute and write per line memory in its
// exec state. An accepted sample passes the command queue, the back end and the
// result queue; with both outputs enabled the wet result follows the dry one.
// Synchronous active-low reset clears control and fill flags and loads config
// defaults; memory contents are masked by per-line fill flags, no clearing pass is run.
module stereo_multitap_delay_chorus_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [smtd_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [smtd_pkg::OUT_BITS-1:0] o_sample_out,
    output logic                                o_is_wet,
    output logic                                o_channel,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic [smtd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smtd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import smtd_pkg::*;

    t_cmd cmd;
    t_res res;
    t_cfg cfg;
    logic cmd_valid, cmd_pop, res_push, res_ready;

    always_comb begin
        cfg.we    = i_cfg_we;
        cfg.index = i_cfg_index;
        cfg.data  = i_cfg_data;
    end

    smtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_in (i_sample_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    smtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    smtd_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (res_push),
        .i_res        (res),
        .o_res_ready  (res_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_is_wet     (o_is_wet),
        .o_channel    (o_channel),
        .o_last       (o_last)
    );

endmodule

// File: design/smtd_checker.sv
// Port-level checks for the delay chorus top level, and the bind that
// attaches them. Uses smtd_pkg for port widths.
module smtd_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [smtd_pkg::OUT_BITS-1:0] o_sample_out,
    input logic                                 o_is_wet,
    input logic                                 o_channel,
    input logic                                 o_last
);
    import smtd_pkg::*;

    // stalled result request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample_out)
                                   && $stable(o_is_wet) && $stable(o_last)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // wet result always closes the sample
    a_wet_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_wet) |-> o_last)
        else $error("wet result not marked last");

    // a dry result that is not last is followed by the wet one, same channel
    a_dry_then_wet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=>
            (o_valid && o_is_wet && (o_channel == $past(o_channel))))
        else $error("dry result not followed by wet of same channel");

endmodule

bind stereo_multitap_delay_chorus_unit smtd_checker u_smtd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sample_out (o_sample_out),
    .o_is_wet     (o_is_wet),
    .o_channel    (o_channel),
    .o_last       (o_last)
);
